>>> design/afla_pkg.sv
// Shared constants and types for the averaged frequency load adjuster.
package afla_pkg;

   // Table geometry and field widths.
   localparam int NUM_GENERATORS   = 16;
   localparam int SPEED_WIDTH      = 24;
   localparam int GEN_INDEX_WIDTH  = 4;
   localparam int TABLE_ADDR_WIDTH = $clog2(NUM_GENERATORS);
   localparam int GAIN_WIDTH       = 24;
   localparam int LIMIT_WIDTH      = 17;
   localparam int ADJ_WIDTH        = 18;

   // Datapath widths derived from the table geometry.
   localparam int SUM_WIDTH     = SPEED_WIDTH + TABLE_ADDR_WIDTH;
   localparam int COUNT_WIDTH   = $clog2(NUM_GENERATORS + 1);
   localparam int AVG_WIDTH     = SPEED_WIDTH + 1;
   localparam int PROD_WIDTH    = AVG_WIDTH + GAIN_WIDTH + 1;
   localparam int FRAC_BITS     = 16;
   localparam int SHIFT_WIDTH   = PROD_WIDTH - FRAC_BITS;
   localparam int DIV_STEPS     = SUM_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 24;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_SCALE   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADJUST_LIMIT = 1'b1;
   localparam logic [GAIN_WIDTH-1:0]      GAIN_RESET       = 24'd65536;
   localparam logic [LIMIT_WIDTH-1:0]     LIMIT_RESET      = 17'd19661;

   // Request to the divider: launch with dividend and divisor.
   typedef struct packed {
      logic                   launch;
      logic [SUM_WIDTH-1:0]   dividend;
      logic [COUNT_WIDTH-1:0] divisor;
   } div_req_type;

   // Status from the divider: busy while iterating, done for one cycle.
   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [SUM_WIDTH-1:0] quotient;
   } div_rsp_type;

endpackage

>>> design/averaged_frequency_load_adjust.sv
// Top level: speed table update, average, gain, clamp and change detection.
// Each accepted transaction runs the update, launch, divide, multiply and finish steps in order;
// an empty table skips divide and multiply. Busy stays high until the previous one is done.
// The divide step runs the 28-step iterative divider of the sum by the active count.
// Reset: synchronous; all generators present with speed zero, registers at their defaults.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
module averaged_frequency_load_adjust (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [afla_pkg::GEN_INDEX_WIDTH-1:0]  req_generator_index,
   input  logic                                  req_breaker_open,
   input  logic signed [afla_pkg::SPEED_WIDTH-1:0] req_rotor_speed,
   output logic                                  rsp_valid,
   output logic signed [afla_pkg::ADJ_WIDTH-1:0] rsp_load_adjustment,
   input  logic                                  csr_write_enable,
   input  logic [afla_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [afla_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   import afla_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // Control and configuration registers.
   logic [NUM_GENERATORS-1:0]     entry_valid_ff, entry_valid_in;
   logic [NUM_GENERATORS-1:0]     written_ff, written_in;
   logic signed [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic signed [ADJ_WIDTH-1:0]   last_ff, last_in;
   logic [GAIN_WIDTH-1:0]         gain_ff, gain_in;
   logic [LIMIT_WIDTH-1:0]        limit_ff, limit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          empty_ff, empty_in;

   // Payload registers.
   logic [GEN_INDEX_WIDTH-1:0]    idx_ff;
   logic                          open_ff;
   logic signed [SPEED_WIDTH-1:0] speed_ff;
   logic                          neg_ff, neg_in;
   logic signed [AVG_WIDTH-1:0]   avg_ff, avg_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [ADJ_WIDTH-1:0]   rsp_adj_ff, rsp_adj_in;

   // Combinational helpers.
   logic                          accept;
   logic                          in_range;
   logic [TABLE_ADDR_WIDTH-1:0]   addr;
   logic [SPEED_WIDTH-1:0]        rd_data;
   logic signed [SPEED_WIDTH-1:0] old_speed;
   logic                          was_valid;
   logic signed [SUM_WIDTH:0]     sum_wide;
   logic                          mem_wr_en;
   logic [SUM_WIDTH-1:0]          sum_abs;
   logic [AVG_WIDTH-1:0]          avg_mag;
   logic signed [SHIFT_WIDTH-1:0] shifted;
   logic signed [SHIFT_WIDTH-1:0] lim_wide;
   logic signed [ADJ_WIDTH-1:0]   lim_pos;
   logic signed [ADJ_WIDTH-1:0]   adj_val;
   div_req_type                   div_req;
   div_rsp_type                   div_rsp;

   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);
   assign in_range = (32'(idx_ff) < NUM_GENERATORS);
   assign addr     = idx_ff[TABLE_ADDR_WIDTH-1:0];

   // Speed table.
   afla_speed_mem u_speed_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (addr),
      .wr_data (speed_ff),
      .rd_en   (accept),
      .rd_addr (req_generator_index[TABLE_ADDR_WIDTH-1:0]),
      .rd_data (rd_data)
   );

   // Divider of the speed sum by the active count.
   afla_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // An entry never written since reset reads as zero.
   assign old_speed = written_ff[addr] ? $signed(rd_data) : '0;
   assign was_valid = entry_valid_ff[addr];
   assign mem_wr_en = (state_ff == ST_UPDATE) && in_range && !open_ff;

   // New running sum after removing the old entry if present and adding the new speed if the breaker is closed.
   always_comb begin
      sum_wide = (SUM_WIDTH+1)'(sum_ff);
      if (was_valid) begin
         sum_wide = sum_wide - (SUM_WIDTH+1)'(old_speed);
      end
      if (!open_ff) begin
         sum_wide = sum_wide + (SUM_WIDTH+1)'(speed_ff);
      end
   end

   // Divider launch and sign handling.
   assign sum_abs          = sum_ff[SUM_WIDTH-1] ? SUM_WIDTH'(-sum_ff) : SUM_WIDTH'(sum_ff);
   assign div_req.launch   = (state_ff == ST_LAUNCH) && (count_ff != '0);
   assign div_req.dividend = sum_abs;
   assign div_req.divisor  = count_ff;
   assign avg_mag          = div_rsp.quotient[AVG_WIDTH-1:0];

   // Scaling and clamp.
   assign shifted  = prod_ff[PROD_WIDTH-1:FRAC_BITS];
   assign lim_wide = $signed(SHIFT_WIDTH'(limit_ff));
   assign lim_pos  = $signed(ADJ_WIDTH'(limit_ff));

   always_comb begin
      if (empty_ff) begin
         adj_val = -lim_pos;
      end else if (shifted > lim_wide) begin
         adj_val = lim_pos;
      end else if (shifted < -lim_wide) begin
         adj_val = -lim_pos;
      end else begin
         adj_val = shifted[ADJ_WIDTH-1:0];
      end
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in       = state_ff;
      entry_valid_in = entry_valid_ff;
      written_in     = written_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      last_in        = last_ff;
      gain_in        = gain_ff;
      limit_in       = limit_ff;
      rsp_valid_in   = 1'b0;
      rsp_adj_in     = rsp_adj_ff;
      empty_in       = empty_ff;
      neg_in         = neg_ff;
      avg_in         = avg_ff;
      prod_in        = prod_ff;

      // Configuration writes.
      if (csr_write_enable) begin
         case (csr_index)
            CSR_GAIN_SCALE: begin
               gain_in = csr_write_data[GAIN_WIDTH-1:0];
            end
            CSR_ADJUST_LIMIT: begin
               limit_in = csr_write_data[LIMIT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (in_range) begin
               sum_in               = sum_wide[SUM_WIDTH-1:0];
               count_in             = count_ff - COUNT_WIDTH'(was_valid)
                                      + COUNT_WIDTH'(!open_ff);
               entry_valid_in[addr] = !open_ff;
               if (!open_ff) begin
                  written_in[addr] = 1'b1;
               end
            end
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            neg_in   = sum_ff[SUM_WIDTH-1];
            empty_in = (count_ff == '0);
            state_in = (count_ff == '0) ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               avg_in   = neg_ff ? $signed(-avg_mag) : $signed(avg_mag);
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            // Both factors are sign-extended to the full product width first.
            prod_in  = PROD_WIDTH'(avg_ff) * PROD_WIDTH'($signed({1'b0, gain_ff}));
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (adj_val != last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_adj_in   = adj_val;
               last_in      = adj_val;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, control registers and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_valid_ff <= '1;
         written_ff     <= '0;
         sum_ff         <= '0;
         count_ff       <= COUNT_WIDTH'(NUM_GENERATORS);
         last_ff        <= '0;
         gain_ff        <= GAIN_RESET;
         limit_ff       <= LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
         rsp_adj_ff     <= '0;
         empty_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_valid_ff <= entry_valid_in;
         written_ff     <= written_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         last_ff        <= last_in;
         gain_ff        <= gain_in;
         limit_ff       <= limit_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_adj_ff     <= rsp_adj_in;
         empty_ff       <= empty_in;
      end
   end

   // Payload registers; the request fields are captured with the transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff   <= req_generator_index;
         open_ff  <= req_breaker_open;
         speed_ff <= req_rotor_speed;
      end
      neg_ff     <= neg_in;
      avg_ff     <= avg_in;
      prod_ff    <= prod_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_load_adjustment = rsp_adj_ff;

   // The active count always matches the number of present generators.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(entry_valid_ff))
      else $error("active count differs from the presence bits");

   // A result only follows the final sequencer step.
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ST_FINISH)
      else $error("result strobe outside the final step");

   // A result always carries a new value, which becomes the last value.
   a_rsp_is_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_adj_ff == last_ff) && (last_ff != $past(last_ff)))
      else $error("result does not report a change");

   // The divider is idle whenever the block is idle.
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_rsp.busy)
      else $error("divider running while the block is idle");

   // Waiting on the divider implies it was started.
   a_divide_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) && $past(state_ff) == ST_DIVIDE |-> $past(div_rsp.busy))
      else $error("waiting on a divider that is not running");

endmodule

>>> design/afla_speed_mem.sv
// Speed table memory: one write port, one registered read port.
module afla_speed_mem (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [afla_pkg::TABLE_ADDR_WIDTH-1:0] wr_addr,
   input  logic [afla_pkg::SPEED_WIDTH-1:0]      wr_data,
   input  logic                                  rd_en,
   input  logic [afla_pkg::TABLE_ADDR_WIDTH-1:0] rd_addr,
   output logic [afla_pkg::SPEED_WIDTH-1:0]      rd_data
);
   import afla_pkg::*;

   logic [SPEED_WIDTH-1:0] mem [NUM_GENERATORS];
   logic [SPEED_WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, enabled by rd_en.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/afla_divider.sv
// Iterative restoring divider: one quotient bit per cycle.
module afla_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  afla_pkg::div_req_type div_req,
   output afla_pkg::div_rsp_type div_rsp
);
   import afla_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0] step_ff, step_in;
   logic [COUNT_WIDTH-1:0]   rem_ff, rem_in;
   logic [SUM_WIDTH-1:0]     quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]   divisor_ff, divisor_in;
   logic [COUNT_WIDTH:0]     trial;
   logic                     fits;

   // One step: shift in the next dividend bit and try to subtract.
   always_comb begin
      trial      = {rem_ff, quo_ff[SUM_WIDTH-1]};
      fits       = (trial >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.launch && !busy_ff) begin
         busy_in    = 1'b1;
         step_in    = DIV_CNT_WIDTH'(DIV_STEPS - 1);
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? COUNT_WIDTH'(trial - {1'b0, divisor_ff}) : trial[COUNT_WIDTH-1:0];
         quo_in = {quo_ff[SUM_WIDTH-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
